// File: hw/rtl/ptq_pkg.sv
// Package for the priority task queue: depth, codes, word and entry types.
// Used by the interfaces, the cell and the top level; depends on nothing.
`timescale 1ns / 1ps

package ptq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_TAKE   = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] task_id;
		logic [7:0]  prio;
		logic [15:0] exec_time;
		logic [15:0] period_len;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_task_id;
		logic [7:0]  out_prio;
		logic [15:0] out_exec_time;
		logic [15:0] out_period;
		logic [4:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
		logic [15:0] exec_time;
		logic [15:0] period;
	} entry_t;

	typedef struct packed {
		logic ins_en;
		logic del_en;
		logic take;
	} cell_ctl_t;

endpackage

// File: hw/rtl/ptq_req_if.sv
// Request channel of the priority task queue: valid, ready and one request word.
// Depends on ptq_pkg for the word type.
`timescale 1ns / 1ps

interface ptq_req_if;
	logic          valid;
	logic          ready;
	ptq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/ptq_rsp_if.sv
// Response channel of the priority task queue: valid, ready and one result word.
// Depends on ptq_pkg for the word type.
`timescale 1ns / 1ps

interface ptq_rsp_if;
	logic          valid;
	logic          ready;
	ptq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/ptq_cell.sv
// One slot of the sorted queue: holds an entry, compares it with the request,
// shifts toward the tail on insert and toward the head on delete. Uses ptq_pkg.
`timescale 1ns / 1ps

module ptq_cell (
	input  logic               clk,
	input  logic               valid,
	input  ptq_pkg::cell_ctl_t ctl,
	input  ptq_pkg::entry_t    new_entry,
	input  ptq_pkg::entry_t    left_entry,
	input  ptq_pkg::entry_t    right_entry,
	input  logic               go_in,
	output logic               go_out,
	input  logic               found_in,
	output logic               found_out,
	output logic               hit,
	output ptq_pkg::entry_t    entry
);
	import ptq_pkg::*;

	entry_t entry_q;
	logic   goes;
	logic   match;

	assign goes      = !valid || (entry_q.prio < new_entry.prio);
	assign go_out    = goes;
	assign match     = ctl.del_en && valid && (ctl.take || (entry_q.id == new_entry.id));
	assign found_out = found_in || match;
	assign hit       = match && !found_in;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (go_in) begin
				entry_q <= left_entry;
			end else if (goes) begin
				entry_q <= new_entry;
			end
		end else if (found_out) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: hw/rtl/priority_task_queue_top.sv
// Top level of the priority task queue: a row of ptq_cell slots kept in
// priority order, the entry count and the result register. Uses ptq_pkg and
// the ptq_req_if / ptq_rsp_if channel interfaces.
//
// Channel  Dir  Word                                             Handshake
// req      in   func, task_id, prio, exec_time, period_len       valid/ready
// rsp      out  status, out_task_id, out_prio, out_exec_time,
//               out_period, entry_count                          valid/ready
//
// On each request all cells compare and shift in the same edge, and the result
// appears in the result register on the following cycle.
// One request per cycle is sustained while results are taken as they appear.
// A request is taken while the result register is empty or being emptied.
// Reset clears the entry count and the result valid; slot contents are kept.
`timescale 1ns / 1ps

module priority_task_queue_top (
	input  logic clk,
	input  logic arst_n,
	ptq_req_if.sink   req,
	ptq_rsp_if.source rsp
);
	import ptq_pkg::*;

	logic [CNT_W-1:0]       used_count_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_data_q;
	logic                   accept;
	logic                   full;
	logic                   is_del;
	cell_ctl_t              ctl;
	entry_t                 new_entry;
	entry_t                 entries   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valids;
	logic [QUEUE_DEPTH-1:0] hits;
	logic [QUEUE_DEPTH:0]   go_chain;
	logic [QUEUE_DEPTH:0]   found_chain;
	entry_t                 sel_entry;
	logic [CNT_W-1:0]       count_next;
	logic [1:0]             status_next;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = used_count_q >= CNT_W'(QUEUE_DEPTH);
	assign is_del    = (req.data.func == FUNC_REMOVE) || (req.data.func == FUNC_TAKE);

	assign ctl.ins_en = accept && (req.data.func == FUNC_INSERT) && !full;
	assign ctl.del_en = accept && is_del;
	assign ctl.take   = req.data.func == FUNC_TAKE;

	assign new_entry.id        = req.data.task_id;
	assign new_entry.prio      = req.data.prio;
	assign new_entry.exec_time = req.data.exec_time;
	assign new_entry.period    = req.data.period_len;

	assign go_chain[0]    = 1'b0;
	assign found_chain[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		entry_t left_e;
		entry_t right_e;

		assign valids[i] = IDX < used_count_q;
		assign left_e    = (i == 0) ? new_entry : entries[(i == 0) ? 0 : i - 1];
		assign right_e   = (i == QUEUE_DEPTH - 1) ? entries[i]
		                 : entries[(i == QUEUE_DEPTH - 1) ? i : i + 1];

		ptq_cell u_cell (
			.clk         (clk),
			.valid       (valids[i]),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.go_in       (go_chain[i]),
			.go_out      (go_chain[i+1]),
			.found_in    (found_chain[i]),
			.found_out   (found_chain[i+1]),
			.hit         (hits[i]),
			.entry       (entries[i])
		);
	end

	always_comb begin
		sel_entry = '0;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			sel_entry = sel_entry | (hits[k] ? entries[k] : '0);
		end
	end

	always_comb begin
		count_next  = used_count_q;
		status_next = ST_OK;
		case (req.data.func)
			FUNC_INSERT: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					count_next = used_count_q + 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (found_chain[QUEUE_DEPTH]) begin
					count_next = used_count_q - 1'b1;
				end else begin
					status_next = ST_NOT_FOUND;
				end
			end
			FUNC_TAKE: begin
				if (found_chain[QUEUE_DEPTH]) begin
					count_next = used_count_q - 1'b1;
				end else begin
					status_next = ST_EMPTY;
				end
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_count_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				used_count_q <= count_next;
				rsp_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_data_q.status        <= status_next;
			rsp_data_q.out_task_id   <= sel_entry.id;
			rsp_data_q.out_prio      <= sel_entry.prio;
			rsp_data_q.out_exec_time <= sel_entry.exec_time;
			rsp_data_q.out_period    <= sel_entry.period;
			rsp_data_q.entry_count   <= count_next;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hits))
		else $error("more than one cell claims the delete");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("accepted request produced no result");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.data.func == FUNC_INSERT) && full)
		|=> (rsp.data.status == ST_FULL) && $stable(used_count_q))
		else $error("insert into full queue was not refused");

endmodule

// File: tb/sv/ptq_result_checker.sv
// Result checker for the priority task queue: watches the request and response
// channels, keeps its own sorted copy of the queue and compares every result word.
// Depends on ptq_pkg and the ptq_req_if / ptq_rsp_if interfaces.
`timescale 1ns / 1ps

module ptq_result_checker (
	input  logic clk,
	ptq_req_if   req,
	ptq_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	import ptq_pkg::*;

	entry_t slots [QUEUE_DEPTH];
	int     held = 0;
	int     mismatches = 0;
	int     pending_r = 0;
	rsp_t   expected_results [$];

	assign fail_count = mismatches;
	assign pending    = pending_r;

	function automatic entry_t pull_slot(int pos);
		entry_t e;
		int     i;
		e = slots[pos];
		for (i = pos; i + 1 < held; i++)
			slots[i] = slots[i + 1];
		held--;
		return e;
	endfunction

	function automatic rsp_t apply_queue_op(req_t w);
		rsp_t   r;
		entry_t e;
		int     i;
		int     pos;
		r = '0;
		e = '0;
		r.status = ST_OK;
		case (w.func)
			FUNC_INSERT: begin
				if (held >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < held && slots[pos].prio >= w.prio)
						pos++;
					for (i = held; i > pos; i--)
						slots[i] = slots[i - 1];
					slots[pos] = '{w.task_id, w.prio, w.exec_time, w.period_len};
					held++;
				end
			end
			FUNC_REMOVE: begin
				pos = 0;
				while (pos < held && slots[pos].id != w.task_id)
					pos++;
				if (pos == held)
					r.status = ST_NOT_FOUND;
				else
					e = pull_slot(pos);
			end
			FUNC_TAKE: begin
				if (held == 0)
					r.status = ST_EMPTY;
				else
					e = pull_slot(0);
			end
			default: begin
			end
		endcase
		r.out_task_id   = e.id;
		r.out_prio      = e.prio;
		r.out_exec_time = e.exec_time;
		r.out_period    = e.period;
		r.entry_count   = 5'(held);
		return r;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (rsp.valid && rsp.ready) begin
			got = rsp.data;
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result word with none expected: st=%0d id=%h cnt=%0d",
						$time, got.status, got.out_task_id, got.entry_count);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.out_task_id !== want.out_task_id ||
						got.out_prio !== want.out_prio ||
						got.out_exec_time !== want.out_exec_time ||
						got.out_period !== want.out_period ||
						got.entry_count !== want.entry_count) begin
					if (mismatches < 10)
						$display({"%0t: result word mismatch, expected st=%0d id=%h pr=%h ",
							"tm=%h pe=%h cnt=%0d, got st=%0d id=%h pr=%h tm=%h pe=%h cnt=%0d"},
							$time, want.status, want.out_task_id, want.out_prio,
							want.out_exec_time, want.out_period, want.entry_count,
							got.status, got.out_task_id, got.out_prio,
							got.out_exec_time, got.out_period, got.entry_count);
					mismatches++;
				end
			end
		end
		if (req.valid && req.ready)
			expected_results.push_back(apply_queue_op(req.data));
		pending_r <= expected_results.size();
	end

endmodule

// File: tb/sv/priority_task_queue_top_tb.sv
// Testbench top for the priority task queue: clock, reset, request stimulus,
// response stalls, watchdog and verdict. Depends on ptq_pkg, the channel
// interfaces, priority_task_queue_top and ptq_result_checker.
`timescale 1ns / 1ps

module priority_task_queue_top_tb;
	import ptq_pkg::*;

	localparam int RANDOM_WORDS = 925;
	localparam int IDLE_LIMIT   = 4000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_cycles = 0;
	bit   filling = 1'b1;
	int   phase_left = 0;

	ptq_req_if req ();
	ptq_rsp_if rsp ();

	priority_task_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	ptq_result_checker result_check (
		.clk        (clk),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic req_t make_word(func_t f, logic [15:0] id, logic [7:0] pr,
			logic [15:0] tm, logic [15:0] pe);
		req_t w;
		w.func       = f;
		w.task_id    = id;
		w.prio       = pr;
		w.exec_time  = tm;
		w.period_len = pe;
		return w;
	endfunction

	function automatic req_t next_random_word();
		func_t       f;
		int          pick;
		logic [15:0] id;
		logic [7:0]  pr;
		logic [15:0] pe;
		if (phase_left == 0) begin
			filling    = !filling;
			phase_left = $urandom_range(20, 60);
		end
		phase_left--;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			f = FUNC_NOP;
		else if (filling)
			f = (pick < 65) ? FUNC_INSERT : (pick < 85) ? FUNC_REMOVE : FUNC_TAKE;
		else
			f = (pick < 25) ? FUNC_INSERT : (pick < 60) ? FUNC_REMOVE : FUNC_TAKE;
		id = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
			: 16'($urandom_range(0, 23));
		pr = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 3));
		pe = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
		return make_word(f, id, pr, 16'($urandom_range(0, 65535)), pe);
	endfunction

	task automatic send_word(input req_t w);
		req.data  <= w;
		req.valid <= 1'b1;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(16, 160);
			end
			left--;
			case (mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= 1'($urandom_range(0, 1));
				default: rsp.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		req_t directed [$];
		int   sent;
		int   burst;
		int   n;
		int   i;
		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue cases, fill past full, ties at both priority ends, deletes.
		directed.push_back(make_word(FUNC_TAKE, 16'h0000, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_word(FUNC_REMOVE, 16'h0005, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_word(FUNC_NOP, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
		directed.push_back(make_word(FUNC_INSERT, 16'h0000, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_word(FUNC_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
		directed.push_back(make_word(FUNC_INSERT, 16'h0001, 8'hFF, 16'h1234, 16'h0000));
		directed.push_back(make_word(FUNC_INSERT, 16'h0002, 8'h80, 16'h00FF, 16'h0010));
		directed.push_back(make_word(FUNC_INSERT, 16'h0003, 8'h00, 16'hFF00, 16'h0020));
		directed.push_back(make_word(FUNC_INSERT, 16'h0002, 8'h80, 16'h0F0F, 16'hF0F0));
		for (i = 0; i < 10; i++)
			directed.push_back(make_word(FUNC_INSERT, 16'(100 + i), 8'(i * 25),
				16'(i * 7), 16'(i * 300)));
		directed.push_back(make_word(FUNC_INSERT, 16'hAAAA, 8'h55, 16'h5555, 16'hAAAA));
		directed.push_back(make_word(FUNC_NOP, 16'h0000, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_word(FUNC_REMOVE, 16'h0002, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_word(FUNC_REMOVE, 16'h1234, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_word(FUNC_TAKE, 16'h0000, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_word(FUNC_INSERT, 16'h5555, 8'hAA, 16'hAAAA, 16'h5555));
		for (i = 0; i < directed.size(); i++)
			send_word(directed[i]);
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			for (n = 0; n < burst && sent < RANDOM_WORDS; n++) begin
				send_word(next_random_word());
				sent++;
			end
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if ($urandom_range(0, 9) == 0) begin
				while (pending != 0)
					@(posedge clk);
			end
		end

		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
